>>> hw/rtl/id3s_pkg.sv
package id3s_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 28;
  localparam int unsigned IdxW  = 4;

  localparam logic [ByteW-1:0] MagicI = 8'h49;
  localparam logic [ByteW-1:0] MagicD = 8'h44;
  localparam logic [ByteW-1:0] Magic3 = 8'h33;

  localparam logic [ByteW-1:0] SyncMask  = 8'h7F;
  localparam logic [IdxW-1:0]  HdrFirst  = 4'd3;
  localparam logic [IdxW-1:0]  SizeFirst = 4'd6;
  localparam logic [IdxW-1:0]  HdrLast   = 4'd9;

  localparam logic CmdData  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } res_t;

  function automatic logic [ByteW-1:0] magic_byte(input logic [1:0] idx);
    logic [ByteW-1:0] r;
    unique case (idx)
      2'd0:    r = MagicI;
      2'd1:    r = MagicD;
      default: r = Magic3;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/id3s_parse.sv
module id3s_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_i,
  input  logic                  cmd_i,
  input  logic [7:0]            byte_i,
  output id3s_pkg::res_t        res_o
);
  import id3s_pkg::*;

  typedef enum logic [1:0] {
    PhPrefix = 2'd0,
    PhHeader = 2'd1,
    PhSkip   = 2'd2,
    PhPass   = 2'd3
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       pm_q, pm_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [1:0]       pm;
  logic [SizeW-1:0] rem_sh;
  logic             hit;

  assign pm     = (pm_q > 2'd2) ? 2'd2 : pm_q;
  assign hit    = (byte_i == magic_byte(pm));
  assign rem_sh = {rem_q[SizeW-8:0], byte_i[6:0] & SyncMask[6:0]};

  always_comb begin
    phase_d = phase_q;
    pm_d    = pm_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    res_o   = '{cnt: 2'd0, b0: byte_i, b1: byte_i, b2: byte_i};
    if (cmd_i == CmdFlush) begin
      phase_d = PhPrefix;
      pm_d    = 2'd0;
      idx_d   = '0;
      rem_d   = '0;
    end else begin
      unique case (phase_q)
        PhPrefix: begin
          if (hit) begin
            if (pm == 2'd2) begin
              phase_d = PhHeader;
              idx_d   = HdrFirst;
              rem_d   = '0;
              pm_d    = 2'd0;
            end else begin
              pm_d = pm + 2'd1;
            end
          end else begin
            res_o.cnt = pm + 2'd1;
            res_o.b0  = (pm == 2'd0) ? byte_i : MagicI;
            res_o.b1  = (pm == 2'd2) ? MagicD : byte_i;
            pm_d      = 2'd0;
            phase_d   = PhPass;
          end
        end
        PhHeader: begin
          if (idx_q >= SizeFirst) begin
            rem_d = rem_sh;
          end
          if (idx_q >= HdrLast) begin
            idx_d   = '0;
            phase_d = (rem_d == '0) ? PhPass : PhSkip;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PhSkip: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 28'd1;
          end
          if (rem_d == '0) begin
            phase_d = PhPass;
          end
        end
        default: begin
          res_o.cnt = 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPrefix;
      pm_q    <= 2'd0;
      idx_q   <= '0;
      rem_q   <= '0;
    end else if (req_i) begin
      phase_q <= phase_d;
      pm_q    <= pm_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
    end
  end

endmodule

>>> hw/rtl/id3v2_tag_stripper_core.sv
// Strips a leading ID3v2 tag from a byte stream. Each input request carries one
// byte (tuser low) or a flush (tuser high) that returns the block to stream start.
// A held "I" or "ID" prefix is replayed ahead of the byte that breaks the match;
// after a full "ID3" the 10-byte header and the syncsafe-sized body are dropped,
// then bytes pass through unchanged. tlast marks the final output byte of each
// input request. Throughput is one byte per cycle while the output is ready; a
// request that replays a held prefix yields two or three output bytes, and the
// input stalls until the three-entry output buffer has drained to its last byte.
module id3v2_tag_stripper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // last_of_run
);
  import id3s_pkg::*;

  logic [1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] b0_q, b1_q, b2_q;
  logic [ByteW-1:0] b0_d, b1_d, b2_d;
  logic             acc, pop;
  res_t             res;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = b0_q;
  assign m_axis_tlast  = (cnt_q == 2'd1);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  id3s_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (acc),
    .cmd_i  (s_axis_tuser),
    .byte_i (s_axis_tdata),
    .res_o  (res)
  );

  always_comb begin
    cnt_d = cnt_q;
    b0_d  = b0_q;
    b1_d  = b1_q;
    b2_d  = b2_q;
    priority if (acc && (res.cnt != 2'd0)) begin
      cnt_d = res.cnt;
      b0_d  = res.b0;
      b1_d  = res.b1;
      b2_d  = res.b2;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      b0_d  = b1_q;
      b1_d  = b2_q;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
    b2_q <= b2_d;
  end

endmodule

>>> hw/rtl/id3s_checker.sv
module id3s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import id3s_pkg::*;

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast && m_axis_tready)
    else $error("input taken while a multi-byte run is pending");

  a_flush_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == CmdFlush) |=> !m_axis_tvalid)
    else $error("flush produced output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind id3v2_tag_stripper_core id3s_checker u_id3s_checker (.*);

>>> sim/id3v2_tag_stripper_core_test.sv
module id3v2_tag_stripper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import id3s_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StreamTarget = 350;

  typedef enum logic [1:0] {PhPrefix, PhHeader, PhBody, PhPass} strip_phase_e;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } out_byte_t;

  class tag_strip_board;
    strip_phase_e     phase;
    logic [1:0]       matched;
    logic [IdxW-1:0]  hdr_idx;
    logic [SizeW-1:0] body_left;
    out_byte_t        due[$];
    int               failures;
    int               shown;

    function new();
      failures = 0;
      shown = 0;
      restart();
    endfunction

    function void restart();
      phase = PhPrefix;
      matched = '0;
      hdr_idx = '0;
      body_left = '0;
    endfunction

    function void push_out(logic [ByteW-1:0] data, logic last);
      out_byte_t o;
      o.data = data;
      o.last = last;
      due.push_back(o);
    endfunction

    function void report(string what, logic [ByteW-1:0] want_data, logic want_last,
                         logic [ByteW-1:0] got_data, logic got_last);
      failures++;
      if (shown < 10) begin
        shown++;
        $display("%s: expected byte %02h last %0b, got byte %02h last %0b",
                 what, want_data, want_last, got_data, got_last);
      end
    endfunction

    // one accepted input request
    function void note_request(logic cmd, logic [ByteW-1:0] data);
      logic [ByteW-1:0] want;
      if (cmd == CmdFlush) begin
        restart();
        return;
      end
      case (phase)
        PhPrefix: begin
          want = (matched == 2'd0) ? MagicI : (matched == 2'd1) ? MagicD : Magic3;
          if (data == want) begin
            if (matched == 2'd2) begin
              phase = PhHeader;
              hdr_idx = HdrFirst;
              body_left = '0;
              matched = '0;
            end else begin
              matched = matched + 2'd1;
            end
          end else begin
            // replay held prefix ahead of the breaking byte
            if (matched > 2'd0) push_out(MagicI, 1'b0);
            if (matched > 2'd1) push_out(MagicD, 1'b0);
            push_out(data, 1'b1);
            matched = '0;
            phase = PhPass;
          end
        end
        PhHeader: begin
          if (hdr_idx >= SizeFirst) body_left = {body_left[SizeW-8:0], data[6:0] & SyncMask[6:0]};
          if (hdr_idx >= HdrLast) begin
            hdr_idx = '0;
            phase = (body_left == '0) ? PhPass : PhBody;
          end else begin
            hdr_idx = hdr_idx + 4'd1;
          end
        end
        PhBody: begin
          if (body_left != '0) body_left = body_left - 28'd1;
          if (body_left == '0) phase = PhPass;
        end
        default: push_out(data, 1'b1);
      endcase
    endfunction

    function void check_output(logic [ByteW-1:0] data, logic last);
      out_byte_t want;
      if (due.size() == 0) begin
        report("unexpected output", 'x, 1'bx, data, last);
        return;
      end
      want = due.pop_front();
      if (data !== want.data || last !== want.last)
        report("output mismatch", want.data, want.last, data, last);
    endfunction

    function void check_drained();
      if (due.size() != 0)
        report("missing output", due[0].data, due[0].last, 'x, 1'bx);
      failures += (due.size() > 0) ? due.size() - 1 : 0;
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic [ByteW-1:0] s_tdata = '0;
  logic             s_tuser = CmdData;
  logic             m_ready = 1'b0;
  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic [ByteW-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  tag_strip_board board = new();
  int unsigned    cycle_count = 0;
  int unsigned    requests_sent = 0;
  int unsigned    hold_requests = 0;
  int unsigned    holds_served = 0;
  int unsigned    hold_left = 0;
  logic           gaps_on = 1'b1;

  id3v2_tag_stripper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("id3v2_tag_stripper_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on demand
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HoldCycles;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !gaps_on || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    logic [ByteW-1:0] got_data;
    logic             got_last;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_ready) begin
        got_data = m_axis_tdata;
        got_last = m_axis_tlast;
        @(posedge clk_i);
        board.check_output(got_data, got_last);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [ByteW-1:0] data);
    while (gaps_on && $urandom_range(99) < 21) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    do @(negedge clk_i); while (!s_axis_tready);
    board.note_request(cmd, data);
    requests_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_tag(input logic [SizeW-1:0] size);
    logic [ByteW-1:0] hdr [10];
    hdr[0] = MagicI;
    hdr[1] = MagicD;
    hdr[2] = Magic3;
    for (int k = 3; k < 6; k++) hdr[k] = 8'($urandom);
    // size bytes carry random top bits, which are masked off
    for (int k = 6; k < 10; k++)
      hdr[k] = {1'($urandom_range(1)), 7'(size >> (7 * (9 - k)))};
    for (int k = 0; k < 10; k++) send_item(CmdData, hdr[k]);
    repeat (size) begin
      send_item(CmdData, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (board.due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(3))
      0:       b = MagicI;
      1:       b = MagicD;
      2:       b = Magic3;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  initial begin
    int iter;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-size tag, then pass-through of extreme bytes
    send_item(CmdFlush, 8'hFF);
    send_tag('0);
    send_item(CmdData, 8'h00);
    send_item(CmdData, 8'hFF);
    // held "I" broken by another byte
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, MagicI);
    send_item(CmdData, 8'hA5);
    // held "ID" broken, including a repeated I
    send_item(CmdFlush, 8'h5A);
    send_item(CmdData, MagicI);
    send_item(CmdData, MagicD);
    send_item(CmdData, MagicI);
    // no tag at all, magic bytes later pass unchanged
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, Magic3);
    send_item(CmdData, MagicI);
    // held prefix discarded by flush
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, MagicI);
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, MagicD);
    // small tag with body, then flush in the middle of a header
    send_item(CmdFlush, 8'h00);
    send_tag(28'd3);
    send_item(CmdData, 8'h7E);
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, MagicI);
    send_item(CmdData, MagicD);
    send_item(CmdData, Magic3);
    send_item(CmdData, 8'h04);
    send_item(CmdFlush, 8'h00);
    send_item(CmdData, 8'h81);
    // size with top bits set at random in each size byte
    send_item(CmdFlush, 8'h00);
    send_tag(28'd130);
    send_item(CmdData, 8'h33);

    iter = 0;
    while (requests_sent < StreamTarget || iter < 10) begin
      gaps_on = !(iter >= 4 && iter < 8);
      if (iter == 1) begin
        // output blocked while input keeps coming
        hold_requests++;
        send_item(CmdFlush, 8'h00);
        repeat (24) send_item(CmdData, 8'($urandom));
      end else if (iter == 3) begin
        wait_drained();
      end
      n = $urandom_range(99);
      if (n < 55) begin
        send_item(CmdFlush, 8'($urandom));
        if ($urandom_range(19) == 0) send_tag(28'($urandom_range(13, 40)));
        else send_tag(28'($urandom_range(0, 12)));
        repeat ($urandom_range(1, 8)) send_item(CmdData, 8'($urandom));
      end else if (n < 75) begin
        send_item(CmdFlush, 8'($urandom));
        n = $urandom_range(2);
        if (n > 0) send_item(CmdData, MagicI);
        if (n > 1) send_item(CmdData, MagicD);
        send_item(CmdData, pick_byte());
        repeat ($urandom_range(0, 4)) send_item(CmdData, 8'($urandom));
      end else if (n < 90) begin
        repeat ($urandom_range(1, 6))
          send_item(($urandom_range(9) == 0) ? CmdFlush : CmdData, pick_byte());
      end else begin
        send_item(CmdFlush, 8'($urandom));
        send_item(CmdData, MagicI);
        send_item(CmdData, MagicD);
        send_item(CmdData, Magic3);
        repeat ($urandom_range(0, 6)) send_item(CmdData, 8'($urandom));
        send_item(CmdFlush, 8'($urandom));
        send_item(CmdData, pick_byte());
      end
      iter++;
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    board.check_drained();
    if (board.failures == 0) begin
      $display("id3v2_tag_stripper_core: match");
    end else begin
      $display("id3v2_tag_stripper_core: mismatch");
    end
    $finish;
  end

endmodule
